### sv/sers_pkg.sv
package sers_pkg;

    localparam int CmdW = 2;
    localparam int FloorW = 4;
    localparam int DirW = 2;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    localparam logic [1:0] DIR_IDLE = 2'd0;
    localparam logic [1:0] DIR_UP   = 2'd1;
    localparam logic [1:0] DIR_DOWN = 2'd2;

    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_MOVING = 2'd1;
    localparam logic [1:0] MODE_DOOR   = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DUP   = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic [1:0] cmd;
        logic [3:0] req_floor;
        logic [1:0] req_dir;
    } t_in_item;

    typedef struct packed {
        logic [3:0] floor;
        logic [1:0] travel_dir;
        logic [1:0] cab_state;
        logic       door_is_open;
        logic [4:0] pending_count;
        logic       next_valid;
        logic [3:0] next_floor;
        logic [1:0] status;
    } t_out_item;

    // True when floor a must be served strictly before floor b.
    function automatic logic goes_before(input logic [3:0] a, input logic [3:0] b,
                                         input logic [3:0] c, input logic [1:0] dir);
        logic [3:0] da;
        logic [3:0] db;
        logic       sa;
        logic       sb;
        da = (a >= c) ? a - c : c - a;
        db = (b >= c) ? b - c : c - b;
        goes_before = 1'b0;
        if (dir == DIR_IDLE) begin
            goes_before = da < db;
        end else if (dir == DIR_UP) begin
            sa = a >= c;
            sb = b >= c;
            if (sa != sb) goes_before = sa;
            else goes_before = sa ? (a < b) : (a > b);
        end else if (dir == DIR_DOWN) begin
            sa = a <= c;
            sb = b <= c;
            if (sa != sb) goes_before = sa;
            else goes_before = sa ? (a > b) : (a < b);
        end
    endfunction

endpackage

### sv/scan_elevator_request_scheduler.sv
// SCAN elevator request scheduler.
// Input channel (i_valid/o_ready, payload i_item) carries one command beat:
// add a request, advance one tick, or clear the table. Output channel
// (o_valid/i_ready, payload o_item) returns one result beat per command with
// the cab floor, direction, mode, door, pending count, next target, status.
// The front stage buffers up to two commands in a queue so the sender keeps
// going while the engine works; the engine runs one command at a time.
// An add walks the table for the duplicate check (one entry per cycle) and
// then runs an insertion sort with one compare-and-shift per cycle. A tick
// that opens the door also compacts the table before its result beat.
// Reset clears the cab to floor 0, idle, door closed and an empty table; no
// clearing pass is needed. When the receiver stalls, the finished result
// waits in the output register and the engine holds before its next result,
// while the front queue still takes up to two beats. The APB register
// start_floor (address 0) places the cab on that floor when written.
module scan_elevator_request_scheduler #(
    parameter int MAX_REQUESTS = 16,
    parameter int NUM_FLOORS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  sers_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output sers_pkg::t_out_item o_item,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic                paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import sers_pkg::*;

    logic       w_q_valid;
    logic       w_q_pop;
    t_in_item   w_q_item;
    logic       w_cfg_we;
    logic [3:0] w_start;

    // Only one register exists; byte address 0 selects it.
    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite && (paddr == 1'b0);
    assign prdata   = (paddr == 1'b0) ? {28'd0, w_start} : 32'd0;

    sers_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_item    (i_item),
        .o_q_valid (w_q_valid),
        .i_q_pop   (w_q_pop),
        .o_q_item  (w_q_item)
    );

    sers_back #(
        .MaxReq    (MAX_REQUESTS),
        .NumFloors (NUM_FLOORS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (w_q_valid),
        .o_q_pop       (w_q_pop),
        .i_q_item      (w_q_item),
        .i_cfg_we      (w_cfg_we),
        .i_cfg_floor   (pwdata[3:0]),
        .o_start_floor (w_start),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_item        (o_item)
    );

endmodule

### sv/sers_front.sv
// Input stage: takes a beat and pushes it into a
// two-entry queue toward the execution engine.
module sers_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  sers_pkg::t_in_item  i_item,
    output logic                o_q_valid,
    input  logic                i_q_pop,
    output sers_pkg::t_in_item  o_q_item
);
    import sers_pkg::*;

    t_in_item   r_q [2];
    logic [1:0] r_cnt;
    logic       w_push;

    assign o_ready   = (r_cnt != 2'd2);
    assign w_push    = i_valid && o_ready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_q[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_q_pop};
        end
        if (i_q_pop) begin
            r_q[0] <= (w_push && r_cnt == 2'd1) ? i_item : r_q[1];
            if (w_push && r_cnt == 2'd2) r_q[1] <= i_item;
        end else if (w_push) begin
            if (r_cnt == 2'd0) r_q[0] <= i_item;
            else r_q[1] <= i_item;
        end
    end

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_pop |-> o_q_valid) else $error("pop from empty queue");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count overflow");
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> !o_ready) else $error("accepted into full queue");

endmodule

### sv/sers_back.sv
// Execution engine: one command at a time, sequencing a duplicate scan,
// a one-step-per-cycle insertion sort and a compaction pass over the table.
module sers_back #(
    parameter int MaxReq = 16,
    parameter int NumFloors = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    output logic                o_q_pop,
    input  sers_pkg::t_in_item  i_q_item,
    input  logic                i_cfg_we,
    input  logic [3:0]          i_cfg_floor,
    output logic [3:0]          o_start_floor,
    output logic                o_valid,
    input  logic                i_ready,
    output sers_pkg::t_out_item o_item
);
    import sers_pkg::*;

    localparam int IdxW = (MaxReq > 1) ? $clog2(MaxReq) : 1;
    localparam int CntW = $clog2(MaxReq + 1);
    localparam logic [3:0] TopFloor =
        (NumFloors > 15) ? 4'd15 : 4'(NumFloors - 1);

    typedef enum logic [2:0] {
        S_IDLE, S_DUP, S_SORT_LOAD, S_SORT_CMP, S_COMPACT, S_EMIT
    } t_state;

    t_state          r_state;
    logic [3:0]      r_floor;
    logic [1:0]      r_dir;
    logic [1:0]      r_mode;
    logic            r_door;
    logic [CntW-1:0] r_count;
    logic [3:0]      r_start;
    logic [3:0]      r_ef [MaxReq];
    logic [1:0]      r_ed [MaxReq];
    logic [CntW-1:0] r_i;
    logic [CntW-1:0] r_j;
    logic [CntW-1:0] r_k;
    logic [3:0]      r_kf;
    logic [1:0]      r_kd;
    logic [3:0]      r_target;
    t_in_item        r_cur;
    logic [1:0]      r_status;
    logic            r_out_v;
    t_out_item       r_out;

    assign o_start_floor = r_start;
    assign o_valid = r_out_v;
    assign o_item  = r_out;
    assign o_q_pop = (r_state == S_IDLE) && i_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_floor  <= 4'd0;
            r_start  <= 4'd0;
            r_dir    <= DIR_IDLE;
            r_mode   <= MODE_IDLE;
            r_door   <= 1'b0;
            r_count  <= '0;
            r_out_v  <= 1'b0;
        end else begin
            if (r_out_v && i_ready && r_state != S_EMIT) r_out_v <= 1'b0;
            if (i_cfg_we) begin
                r_start <= i_cfg_floor;
                r_floor <= (i_cfg_floor > TopFloor) ? TopFloor : i_cfg_floor;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_cur    <= i_q_item;
                        r_status <= ST_OK;
                        r_i      <= '0;
                        unique case (i_q_item.cmd)
                            CMD_ADD: r_state <= S_DUP;
                            CMD_TICK: begin
                                if (r_count == '0) begin
                                    r_dir   <= DIR_IDLE;
                                    r_mode  <= MODE_IDLE;
                                    r_state <= S_EMIT;
                                end else if (r_floor == r_ef[0]) begin
                                    r_mode   <= MODE_DOOR;
                                    r_door   <= 1'b1;
                                    r_target <= r_ef[0];
                                    r_k      <= '0;
                                    r_state  <= S_COMPACT;
                                end else begin
                                    r_door <= 1'b0;
                                    r_mode <= MODE_MOVING;
                                    if (r_floor < r_ef[0]) begin
                                        r_dir   <= DIR_UP;
                                        r_floor <= r_floor + 4'd1;
                                    end else begin
                                        r_dir   <= DIR_DOWN;
                                        r_floor <= r_floor - 4'd1;
                                    end
                                    r_state <= S_EMIT;
                                end
                            end
                            CMD_CLEAR: begin
                                r_count <= '0;
                                r_state <= S_EMIT;
                            end
                            default: r_state <= S_EMIT;
                        endcase
                    end
                end
                S_DUP: begin
                    if (r_i < r_count) begin
                        if (r_ef[r_i[IdxW-1:0]] == r_cur.req_floor &&
                            r_ed[r_i[IdxW-1:0]] == r_cur.req_dir) begin
                            r_status <= ST_DUP;
                            r_state  <= S_EMIT;
                        end else begin
                            r_i <= r_i + 1'b1;
                        end
                    end else if (r_count >= CntW'(MaxReq)) begin
                        r_status <= ST_FULL;
                        r_state  <= S_EMIT;
                    end else if (32'(r_cur.req_floor) >= NumFloors) begin
                        r_status <= ST_RANGE;
                        r_state  <= S_EMIT;
                    end else begin
                        r_ef[r_count[IdxW-1:0]] <= r_cur.req_floor;
                        r_ed[r_count[IdxW-1:0]] <= r_cur.req_dir;
                        r_count <= r_count + 1'b1;
                        r_i     <= CntW'(1);
                        r_state <= S_SORT_LOAD;
                    end
                end
                S_SORT_LOAD: begin
                    if (r_i < r_count) begin
                        r_kf    <= r_ef[r_i[IdxW-1:0]];
                        r_kd    <= r_ed[r_i[IdxW-1:0]];
                        r_j     <= r_i;
                        r_state <= S_SORT_CMP;
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_SORT_CMP: begin
                    // One shift of the insertion per cycle.
                    if (r_j != '0 && goes_before(r_kf, r_ef[IdxW'(r_j - 1'b1)],
                                                 r_floor, r_dir)) begin
                        r_ef[r_j[IdxW-1:0]] <= r_ef[IdxW'(r_j - 1'b1)];
                        r_ed[r_j[IdxW-1:0]] <= r_ed[IdxW'(r_j - 1'b1)];
                        r_j <= r_j - 1'b1;
                    end else begin
                        r_ef[r_j[IdxW-1:0]] <= r_kf;
                        r_ed[r_j[IdxW-1:0]] <= r_kd;
                        r_i     <= r_i + 1'b1;
                        r_state <= S_SORT_LOAD;
                    end
                end
                S_COMPACT: begin
                    if (r_i < r_count) begin
                        if (r_ef[r_i[IdxW-1:0]] != r_target) begin
                            r_ef[r_k[IdxW-1:0]] <= r_ef[r_i[IdxW-1:0]];
                            r_ed[r_k[IdxW-1:0]] <= r_ed[r_i[IdxW-1:0]];
                            r_k <= r_k + 1'b1;
                        end
                        r_i <= r_i + 1'b1;
                    end else begin
                        r_count <= r_k;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (!r_out_v || i_ready) begin
                        r_out_v               <= 1'b1;
                        r_out.floor           <= r_floor;
                        r_out.travel_dir      <= r_dir;
                        r_out.cab_state       <= r_mode;
                        r_out.door_is_open    <= r_door;
                        r_out.pending_count   <= 5'(r_count);
                        r_out.next_valid      <= (r_count != '0);
                        r_out.next_floor      <= (r_count != '0) ? r_ef[0] : 4'd0;
                        r_out.status          <= r_status;
                        r_state               <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(MaxReq)) else $error("table count beyond capacity");
    a_door_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_DOOR) |-> r_door) else $error("door mode with closed door");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> (r_state != S_IDLE)) else $error("popped command not run");

endmodule

### sim/tb.sv
`timescale 1ns / 1ps

// Testbench for the SCAN elevator request scheduler.
// Every command beat that enters the block is run through a local model of the
// cab and the request table. The model produces the result beat the block
// should return. Result beats are compared field by field, oldest first.
module tb;
    import sers_pkg::*;

    localparam int TableDepth = 16;
    localparam int FloorCount = 16;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    t_in_item    i_item;
    logic        o_valid;
    logic        i_ready;
    t_out_item   o_item;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic        paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    scan_elevator_request_scheduler dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_item(i_item),
        .o_valid(o_valid), .i_ready(i_ready), .o_item(o_item),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Clock with an 8 ns period.
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // The model's copy of the cab and of the request table.
    logic [3:0] cab_floor_m;
    logic [1:0] cab_dir_m;
    logic [1:0] cab_mode_m;
    logic       door_m;
    logic [3:0] req_floors [TableDepth];
    logic [1:0] req_dirs [TableDepth];
    int         req_count;

    // Result beats that are still owed by the block, oldest first.
    t_out_item  owed_beats [$];
    int         fail_count;
    int         sender_idle_pct;
    int         receiver_idle_pct;

    // True when floor a has to be served strictly before floor b.
    function automatic bit served_first(logic [3:0] a, logic [3:0] b);
        int da;
        int db;
        bit above_a;
        bit above_b;
        da = (a >= cab_floor_m) ? a - cab_floor_m : cab_floor_m - a;
        db = (b >= cab_floor_m) ? b - cab_floor_m : cab_floor_m - b;
        case (cab_dir_m)
            DIR_IDLE: begin
                return da < db;
            end
            DIR_UP: begin
                above_a = a >= cab_floor_m;
                above_b = b >= cab_floor_m;
                if (above_a != above_b) return above_a;
                return above_a ? (a < b) : (a > b);
            end
            DIR_DOWN: begin
                above_a = a <= cab_floor_m;
                above_b = b <= cab_floor_m;
                if (above_a != above_b) return above_a;
                return above_a ? (a > b) : (a < b);
            end
            default: begin
                return 1'b0;
            end
        endcase
    endfunction

    // Run one command beat through the model and return the result beat.
    function automatic t_out_item schedule_step(t_in_item beat);
        t_out_item  res;
        logic [3:0] fl;
        logic [1:0] dr;
        logic [3:0] target;
        int         j;
        int         kept;
        res = '0;
        res.status = ST_OK;
        case (t_cmd'(beat.cmd))
            CMD_ADD: begin
                // A duplicate is checked first, then a full table, then the range.
                for (int i = 0; i < req_count; i++) begin
                    if (req_floors[i] == beat.req_floor && req_dirs[i] == beat.req_dir) begin
                        res.status = ST_DUP;
                    end
                end
                if (res.status == ST_OK && req_count >= TableDepth) begin
                    res.status = ST_FULL;
                end
                if (res.status == ST_OK && beat.req_floor >= FloorCount) begin
                    res.status = ST_RANGE;
                end
                if (res.status == ST_OK) begin
                    req_floors[req_count] = beat.req_floor;
                    req_dirs[req_count] = beat.req_dir;
                    req_count++;
                    // Stable insertion sort keeps equal keys in their arrival order.
                    for (int i = 1; i < req_count; i++) begin
                        fl = req_floors[i];
                        dr = req_dirs[i];
                        j = i;
                        while (j > 0 && served_first(fl, req_floors[j-1])) begin
                            req_floors[j] = req_floors[j-1];
                            req_dirs[j] = req_dirs[j-1];
                            j--;
                        end
                        req_floors[j] = fl;
                        req_dirs[j] = dr;
                    end
                end
            end
            CMD_TICK: begin
                if (req_count == 0) begin
                    // The cab stops, and the door stays as it is.
                    cab_dir_m = DIR_IDLE;
                    cab_mode_m = MODE_IDLE;
                end else if (cab_floor_m == req_floors[0]) begin
                    // At the target the door opens and every entry for that floor goes.
                    target = req_floors[0];
                    cab_mode_m = MODE_DOOR;
                    door_m = 1'b1;
                    kept = 0;
                    for (int i = 0; i < req_count; i++) begin
                        if (req_floors[i] != target) begin
                            req_floors[kept] = req_floors[i];
                            req_dirs[kept] = req_dirs[i];
                            kept++;
                        end
                    end
                    req_count = kept;
                end else begin
                    door_m = 1'b0;
                    cab_mode_m = MODE_MOVING;
                    if (cab_floor_m < req_floors[0]) begin
                        cab_dir_m = DIR_UP;
                        cab_floor_m++;
                    end else begin
                        cab_dir_m = DIR_DOWN;
                        cab_floor_m--;
                    end
                end
            end
            CMD_CLEAR: begin
                req_count = 0;
            end
            default: begin
            end
        endcase
        res.floor = cab_floor_m;
        res.travel_dir = cab_dir_m;
        res.cab_state = cab_mode_m;
        res.door_is_open = door_m;
        res.pending_count = req_count[4:0];
        res.next_valid = req_count != 0;
        res.next_floor = (req_count != 0) ? req_floors[0] : 4'd0;
        return res;
    endfunction

    // Receiver: stalls at random and checks each accepted result beat.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_valid && i_ready) begin
            if (owed_beats.size() == 0) begin
                $error("result beat with nothing expected: %h", o_item);
                fail_count++;
            end else begin
                want = owed_beats.pop_front();
                if (o_item.floor !== want.floor) begin
                    $error("floor: expected %0d, got %0d", want.floor, o_item.floor);
                    fail_count++;
                end
                if (o_item.travel_dir !== want.travel_dir) begin
                    $error("travel_dir: expected %0d, got %0d",
                           want.travel_dir, o_item.travel_dir);
                    fail_count++;
                end
                if (o_item.cab_state !== want.cab_state) begin
                    $error("cab_state: expected %0d, got %0d",
                           want.cab_state, o_item.cab_state);
                    fail_count++;
                end
                if (o_item.door_is_open !== want.door_is_open) begin
                    $error("door_is_open: expected %0d, got %0d",
                           want.door_is_open, o_item.door_is_open);
                    fail_count++;
                end
                if (o_item.pending_count !== want.pending_count) begin
                    $error("pending_count: expected %0d, got %0d",
                           want.pending_count, o_item.pending_count);
                    fail_count++;
                end
                if (o_item.next_valid !== want.next_valid) begin
                    $error("next_valid: expected %0d, got %0d",
                           want.next_valid, o_item.next_valid);
                    fail_count++;
                end
                if (o_item.next_floor !== want.next_floor) begin
                    $error("next_floor: expected %0d, got %0d",
                           want.next_floor, o_item.next_floor);
                    fail_count++;
                end
                if (o_item.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_item.status);
                    fail_count++;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    // One register write, setup then access; the cab moves to the new floor.
    task automatic write_start_floor(logic [3:0] fl);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 1'b0;
        pwdata <= {28'd0, fl};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cab_floor_m = fl;
    endtask

    // Send one command beat; the model runs when the block accepts it.
    // Valid stays high after the accepting edge until the next idle cycle or
    // the next drain takes it down at the falling edge; the next beat replaces the payload.
    task automatic send_beat(t_in_item beat, bit has_want, t_out_item want);
        t_out_item res;
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_item <= beat;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        res = schedule_step(beat);
        if (has_want && res !== want) begin
            $error("directed row: expected %h, model gives %h", want, res);
            fail_count++;
        end
        owed_beats.insert(owed_beats.size(), res);
        @(negedge i_clk);
    endtask

    // Wait until every owed beat has come, then let the block sit idle before going on.
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (owed_beats.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Build a command: mostly adds and ticks, with clears and the unused code now and then.
    function automatic t_in_item random_beat();
        t_in_item b;
        int pick;
        pick = $urandom_range(99);
        b.cmd = (pick < 45) ? CMD_ADD : (pick < 92) ? CMD_TICK :
                (pick < 97) ? CMD_CLEAR : CMD_NOP;
        b.req_floor = 4'($urandom_range(15));
        b.req_dir = 2'($urandom_range(3));
        return b;
    endfunction

    typedef struct {
        t_in_item  beat;
        bit        has_want;
        t_out_item want;
    } t_row;

    t_row rows [$];

    // Directed row; the expected beat is given only where it is plain to read.
    function automatic void add_row(logic [1:0] c, logic [3:0] f, logic [1:0] d,
                                    bit has_want, t_out_item want);
        t_row r;
        r.beat.cmd = c;
        r.beat.req_floor = f;
        r.beat.req_dir = d;
        r.has_want = has_want;
        r.want = want;
        rows.insert(rows.size(), r);
    endfunction

    initial begin
        t_out_item z;
        t_out_item w;
        z = '0;
        fail_count = 0;
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_item = '0;
        i_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = 1'b0;
        pwdata = '0;
        cab_floor_m = 4'd0;
        cab_dir_m = DIR_IDLE;
        cab_mode_m = MODE_IDLE;
        door_m = 1'b0;
        req_count = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // After reset the cab stands idle at floor 0 with nothing pending.
        w = z;
        add_row(CMD_TICK, 4'd0, DIR_IDLE, 1'b1, w);
        add_row(CMD_NOP, 4'd15, 2'd3, 1'b1, w);
        add_row(CMD_CLEAR, 4'd0, DIR_IDLE, 1'b1, w);
        // The cab is at the only request, so the door opens and the table empties.
        add_row(CMD_ADD, 4'd0, DIR_UP, 1'b0, z);
        w.cab_state = MODE_DOOR;
        w.door_is_open = 1'b1;
        add_row(CMD_TICK, 4'd0, DIR_IDLE, 1'b1, w);
        // A tick on an empty table leaves the door open.
        add_row(CMD_TICK, 4'd0, DIR_IDLE, 1'b0, z);
        add_row(CMD_ADD, 4'd15, 2'd3, 1'b0, z);
        // The same floor and direction again is a duplicate.
        w = z;
        w.pending_count = 5'd1;
        w.next_valid = 1'b1;
        w.next_floor = 4'd15;
        w.status = ST_DUP;
        w.door_is_open = 1'b1;
        add_row(CMD_ADD, 4'd15, 2'd3, 1'b1, w);
        add_row(CMD_ADD, 4'd15, DIR_DOWN, 1'b0, z);
        add_row(CMD_ADD, 4'd4, DIR_IDLE, 1'b0, z);
        add_row(CMD_ADD, 4'd2, DIR_UP, 1'b0, z);
        add_row(CMD_TICK, 4'd0, DIR_IDLE, 1'b0, z);
        add_row(CMD_TICK, 4'd0, DIR_IDLE, 1'b0, z);
        add_row(CMD_TICK, 4'd0, DIR_IDLE, 1'b0, z);
        add_row(CMD_ADD, 4'd1, DIR_DOWN, 1'b0, z);
        add_row(CMD_TICK, 4'd0, DIR_IDLE, 1'b0, z);
        add_row(CMD_TICK, 4'd0, DIR_IDLE, 1'b0, z);
        add_row(CMD_CLEAR, 4'd0, DIR_IDLE, 1'b0, z);
        foreach (rows[i]) send_beat(rows[i].beat, rows[i].has_want, rows[i].want);
        wait_drained();

        // With the cab at floor 15, fill the table with floors 0 upward; the last adds find it full.
        write_start_floor(4'd15);
        for (int i = 0; i < 18; i++) begin
            t_in_item b;
            b.cmd = CMD_ADD;
            b.req_floor = i[3:0];
            b.req_dir = i[5:4];
            send_beat(b, 1'b0, z);
        end
        wait_drained();

        // Random phases, each from a fresh start floor; the sender also pauses
        // for a full drain between bursts.
        for (int phase = 0; phase < 3; phase++) begin
            sender_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 51 : 0;
            receiver_idle_pct = (phase == 0) ? 51 : (phase == 1) ? 24 : 0;
            write_start_floor((phase == 0) ? 4'd0 : (phase == 1) ? 4'd7 : 4'd15);
            for (int n = 0; n < 340; n++) begin
                send_beat(random_beat(), 1'b0, z);
                if (n == 170) wait_drained();
            end
            wait_drained();
        end

        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
